>>> rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// shared types and constants of the circular deque
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DATA_W        = 32;
  localparam int FUNC_W        = 3;
  localparam int CAP_W         = 5;
  localparam int CAP_RESET     = 16;
  localparam int DEPTH_DEFAULT = 16;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_INS_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_INS_REAR  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_DEL_FRONT = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DEL_REAR  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_NONE      = 3'd4;

  // value reported for front and rear of an empty deque
  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic                     empty_res;
    logic                     full_res;
  } res_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic latch;    // capture the request
    logic exec;     // apply the operation, write the slot
    logic read;     // read front and rear slots
    logic cfg_wr;   // load capacity, empty the deque
  } cmd_t;

endpackage

>>> rtl/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque
// double-ended queue in a ring of word slots with a programmable capacity
// ----------------------------------------------------------------------------
// Each request is taken at the rising edge where start is high and busy is
// low, and its result appears on result for exactly one cycle, marked by
// done: the request is captured at the accepting edge, then the EXEC state
// updates the pointers and count and writes the slot, the READ state does
// the registered read of the front and rear slots of the slot memory, and
// the RESP state presents the result. busy stays high until done, so a new
// request is taken at the earliest in the cycle after done. The receiver
// cannot stall: done is a strobe and the result must be taken in that cycle.
// Refused inserts (deque full) and deletes (deque empty) return ok low and
// change nothing; codes other than the four operations are no-ops with ok
// high. Front and rear read -1 while the deque is empty. Writing the
// capacity register (accepted only while busy is low) empties the deque;
// zero counts as one and values above DEPTH saturate at DEPTH.
module circular_deque #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  // request channel
  input  logic                      start,
  output logic                      busy,
  input  cdq_pkg::req_t             req,
  // result strobe
  output logic                      done,
  output cdq_pkg::res_t             result,
  // capacity register write
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [cdq_pkg::CAP_W-1:0] cfg_data
);
  import cdq_pkg::*;

  cmd_t cmd;

  // sequencing only, no data
  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cfg_valid (cfg_valid),
    .busy      (busy),
    .done      (done),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  // slots, pointers, count and result
  cdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req      (req),
    .cfg_data (cfg_data),
    .result   (result)
  );

endmodule

>>> rtl/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// sequencer: accept, update, slot read, result strobe
// ----------------------------------------------------------------------------
module cdq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          cfg_valid,
  output logic          busy,
  output logic          done,
  output logic          cfg_ready,
  output cdq_pkg::cmd_t cmd
);
  import cdq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_READ;
      end
      S_READ: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy       = (state != S_IDLE);
  assign done       = (state == S_RESP);
  assign cfg_ready  = (state == S_IDLE);
  assign cmd.latch  = (state == S_IDLE) && start;
  assign cmd.exec   = (state == S_EXEC);
  assign cmd.read   = (state == S_READ);
  assign cmd.cfg_wr = (state == S_IDLE) && cfg_valid;

endmodule

>>> rtl/cdq_dp.sv
// ----------------------------------------------------------------------------
// cdq_dp
// slot memory, ring pointers, count, capacity and result forming
// ----------------------------------------------------------------------------
module cdq_dp #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cdq_pkg::cmd_t             cmd,
  input  cdq_pkg::req_t             req,
  input  logic [cdq_pkg::CAP_W-1:0] cfg_data,
  output cdq_pkg::res_t             result
);
  import cdq_pkg::*;

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int N_RESET = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

  logic signed [DATA_W-1:0] mem [DEPTH];

  req_t                     req_q;
  logic [CNT_W-1:0]         cap_n;      // effective capacity
  logic [PTR_W-1:0]         front_ptr;
  logic [PTR_W-1:0]         rear_ptr;
  logic [CNT_W-1:0]         count;
  logic                     ok;
  logic signed [DATA_W-1:0] rd_front;
  logic signed [DATA_W-1:0] rd_rear;

  logic [CNT_W-1:0]         cap_sat;
  logic [PTR_W-1:0]         front_inc, front_dec, rear_inc, rear_dec;
  logic                     is_full, is_empty;
  logic                     mem_we;
  logic [PTR_W-1:0]         mem_waddr;
  logic [PTR_W-1:0]         front_ptr_next, rear_ptr_next;
  logic [CNT_W-1:0]         count_next;
  logic                     ok_next;

  // capacity zero acts as one, above depth saturates
  always_comb begin
    if (cfg_data == '0) begin
      cap_sat = CNT_W'(1);
    end else if (32'(cfg_data) > 32'(DEPTH)) begin
      cap_sat = CNT_W'(DEPTH);
    end else begin
      cap_sat = CNT_W'(cfg_data);
    end
  end

  // ring wraps at the effective capacity (cap_n is never zero)
  assign front_inc = (CNT_W'(front_ptr) >= cap_n - CNT_W'(1)) ? '0 : front_ptr + PTR_W'(1);
  assign rear_inc  = (CNT_W'(rear_ptr) >= cap_n - CNT_W'(1)) ? '0 : rear_ptr + PTR_W'(1);
  assign front_dec = (front_ptr == '0) ? PTR_W'(cap_n - CNT_W'(1)) : front_ptr - PTR_W'(1);
  assign rear_dec  = (rear_ptr == '0) ? PTR_W'(cap_n - CNT_W'(1)) : rear_ptr - PTR_W'(1);

  assign is_full  = (count >= cap_n);
  assign is_empty = (count == '0);

  always_comb begin
    front_ptr_next = front_ptr;
    rear_ptr_next  = rear_ptr;
    count_next     = count;
    ok_next        = 1'b1;
    mem_we         = 1'b0;
    mem_waddr      = front_ptr;
    case (req_q.func)
      FUNC_INS_FRONT: begin
        if (is_full) begin
          ok_next = 1'b0;
        end else begin
          mem_we         = 1'b1;
          mem_waddr      = front_ptr;
          front_ptr_next = front_dec;
          count_next     = count + CNT_W'(1);
        end
      end
      FUNC_INS_REAR: begin
        if (is_full) begin
          ok_next = 1'b0;
        end else begin
          mem_we        = 1'b1;
          mem_waddr     = rear_inc;
          rear_ptr_next = rear_inc;
          count_next    = count + CNT_W'(1);
        end
      end
      FUNC_DEL_FRONT: begin
        if (is_empty) begin
          ok_next = 1'b0;
        end else begin
          front_ptr_next = front_inc;
          count_next     = count - CNT_W'(1);
        end
      end
      FUNC_DEL_REAR: begin
        if (is_empty) begin
          ok_next = 1'b0;
        end else begin
          rear_ptr_next = rear_dec;
          count_next    = count - CNT_W'(1);
        end
      end
      default: begin
        ok_next = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_n     <= CNT_W'(N_RESET);
      front_ptr <= '0;
      rear_ptr  <= '0;
      count     <= '0;
    end else if (cmd.cfg_wr) begin
      cap_n     <= cap_sat;
      front_ptr <= '0;
      rear_ptr  <= '0;
      count     <= '0;
    end else if (cmd.exec) begin
      front_ptr <= front_ptr_next;
      rear_ptr  <= rear_ptr_next;
      count     <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) req_q <= req;
    if (cmd.exec)  ok    <= ok_next;
  end

  // slot memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) mem[mem_waddr] <= req_q.value;
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_front <= mem[front_inc];
      rd_rear  <= mem[rear_ptr];
    end
  end

  assign result.ok          = ok;
  assign result.front_value = is_empty ? EMPTY_VALUE : rd_front;
  assign result.rear_value  = is_empty ? EMPTY_VALUE : rd_rear;
  assign result.empty_res   = is_empty;
  assign result.full_res    = (count == cap_n);

endmodule
